>>> sv/protobuf_wire_field_parser_macros.svh
// Assertion macros shared by the protobuf wire field parser RTL.
`ifndef PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PBWF_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define PBWF_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define PBWF_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pbwf_pkg.sv
// Types, codes and helpers shared by the protobuf wire field parser.
`timescale 1ns / 1ps

package pbwf_pkg;

	// Width of the length field of a length-delimited field.
	localparam int LENGTH_BITS = 32;

	// Wire type codes taken from the low three bits of a key.
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef enum logic [2:0] {
		KIND_VARINT  = 3'd0,
		KIND_FIXED32 = 3'd1,
		KIND_FIXED64 = 3'd2,
		KIND_LEN_HDR = 3'd3,
		KIND_PAYLOAD = 3'd4,
		KIND_END     = 3'd5
	} pbwf_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERLONG  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_BAD_WT    = 2'd3
	} pbwf_status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} pbwf_in_t;

	typedef struct packed {
		pbwf_kind_t   kind;
		logic [60:0]  field_tag;
		logic [2:0]   wire_type;
		logic [63:0]  field_value;
		logic         value_wide;
		logic [7:0]   payload_byte;
		logic         payload_end;
		pbwf_status_t status;
		logic         last_of_run;
	} pbwf_out_t;

	// All results caused by one input item: one or two of them.
	typedef struct packed {
		logic      valid;
		logic      second;
		pbwf_out_t res_a;
		pbwf_out_t res_b;
	} pbwf_run_t;

	function automatic pbwf_out_t make_res(input pbwf_kind_t kind, input logic [60:0] tag,
		input logic [2:0] wt, input logic [63:0] val, input logic wide,
		input logic [7:0] pb, input logic pe, input pbwf_status_t st);
		pbwf_out_t r;
		r.kind         = kind;
		r.field_tag    = tag;
		r.wire_type    = wt;
		r.field_value  = val;
		r.value_wide   = wide;
		r.payload_byte = pb;
		r.payload_end  = pe;
		r.status       = st;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	function automatic pbwf_out_t make_end(input pbwf_status_t st);
		return make_res(KIND_END, 61'd0, 3'd0, 64'd0, 1'b0, 8'd0, 1'b0, st);
	endfunction

endpackage

>>> sv/pbwf_decode.sv
// Per-byte field decoder: parser state and the results of one input byte.
`timescale 1ns / 1ps

module pbwf_decode import pbwf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  pbwf_in_t  in_item,
	output pbwf_run_t run
);

	typedef enum logic [2:0] {
		PH_KEY,
		PH_VARINT,
		PH_FIXED,
		PH_LEN,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [63:0]            acc_q, acc_d;
	logic [5:0]             shift_q, shift_d;
	logic [2:0]             fcnt_q, fcnt_d;
	logic [60:0]            tag_q, tag_d;
	logic [2:0]             wt_q, wt_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;

	logic [7:0]   b;
	logic         last;
	logic [63:0]  vacc;
	logic [63:0]  facc;
	logic         overlong;
	logic         too_long;
	logic         fixed_done;
	logic         pay_done;
	logic         main_v;
	pbwf_out_t    main_r;
	logic         end_v;
	pbwf_status_t end_st;
	logic         stop;
	logic         to_discard;
	pbwf_out_t    end_r;

	assign b    = in_item.in_byte;
	assign last = in_item.is_last;

	always_comb begin
		vacc       = acc_q | (64'(b[6:0]) << shift_q);
		facc       = acc_q | (64'(b) << {fcnt_q, 3'b000});
		overlong   = (shift_q == 6'd63) && (b[7:1] != 7'd0);
		too_long   = ((vacc >> (LENGTH_BITS - 1)) >> 1) != 64'd0;
		fixed_done = (wt_q == WT_FIXED64) ? (fcnt_q == 3'd7) : (fcnt_q == 3'd3);
		pay_done   = rem_q == LENGTH_BITS'(1);

		phase_d    = phase_q;
		acc_d      = acc_q;
		shift_d    = shift_q;
		fcnt_d     = fcnt_q;
		tag_d      = tag_q;
		wt_d       = wt_q;
		rem_d      = rem_q;
		main_v     = 1'b0;
		main_r     = make_end(ST_OK);
		end_v      = 1'b0;
		end_st     = ST_OK;
		stop       = 1'b0;
		to_discard = 1'b0;

		unique case (phase_q)
			PH_KEY, PH_VARINT, PH_LEN: begin
				if (overlong) begin
					end_v      = 1'b1;
					end_st     = ST_OVERLONG;
					stop       = 1'b1;
					to_discard = !last;
				end else if (b[7]) begin
					acc_d   = vacc;
					shift_d = shift_q + 6'd7;
					if (last) begin
						end_v  = 1'b1;
						end_st = ST_TRUNCATED;
						stop   = 1'b1;
					end
				end else begin
					acc_d   = 64'd0;
					shift_d = 6'd0;
					if (phase_q == PH_KEY) begin
						tag_d  = vacc[63:3];
						wt_d   = vacc[2:0];
						fcnt_d = 3'd0;
						if (vacc[2:0] == WT_VARINT || vacc[2:0] == WT_FIXED64 ||
							vacc[2:0] == WT_FIXED32 || vacc[2:0] == WT_LEN) begin
							if (vacc[2:0] == WT_VARINT) begin
								phase_d = PH_VARINT;
							end else if (vacc[2:0] == WT_LEN) begin
								phase_d = PH_LEN;
							end else begin
								phase_d = PH_FIXED;
							end
							if (last) begin
								end_v  = 1'b1;
								end_st = ST_TRUNCATED;
								stop   = 1'b1;
							end
						end else begin
							main_v = 1'b1;
							main_r = make_res(KIND_VARINT, vacc[63:3], vacc[2:0], 64'd0,
								1'b0, 8'd0, 1'b0, ST_BAD_WT);
							end_v  = last;
							stop   = last;
						end
					end else if (phase_q == PH_VARINT) begin
						main_v  = 1'b1;
						main_r  = make_res(KIND_VARINT, tag_q, wt_q, vacc,
							vacc[63:32] != 32'd0, 8'd0, 1'b0, ST_OK);
						phase_d = PH_KEY;
						end_v   = last;
						stop    = last;
					end else if (too_long) begin
						end_v      = 1'b1;
						end_st     = ST_TRUNCATED;
						stop       = 1'b1;
						to_discard = !last;
					end else begin
						main_v = 1'b1;
						main_r = make_res(KIND_LEN_HDR, tag_q, wt_q, vacc, 1'b0, 8'd0,
							1'b0, ST_OK);
						if (vacc == 64'd0) begin
							phase_d = PH_KEY;
							end_v   = last;
							stop    = last;
						end else begin
							rem_d   = vacc[LENGTH_BITS-1:0];
							phase_d = PH_PAYLOAD;
							if (last) begin
								end_v  = 1'b1;
								end_st = ST_TRUNCATED;
								stop   = 1'b1;
							end
						end
					end
				end
			end
			PH_FIXED: begin
				if (fixed_done) begin
					main_v  = 1'b1;
					main_r  = make_res((wt_q == WT_FIXED64) ? KIND_FIXED64 : KIND_FIXED32,
						tag_q, wt_q, facc, 1'b0, 8'd0, 1'b0, ST_OK);
					acc_d   = 64'd0;
					fcnt_d  = 3'd0;
					phase_d = PH_KEY;
					end_v   = last;
					stop    = last;
				end else begin
					acc_d  = facc;
					fcnt_d = fcnt_q + 3'd1;
					if (last) begin
						end_v  = 1'b1;
						end_st = ST_TRUNCATED;
						stop   = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_d  = rem_q - LENGTH_BITS'(1);
				main_v = 1'b1;
				main_r = make_res(KIND_PAYLOAD, tag_q, wt_q, 64'd0, 1'b0, b, pay_done, ST_OK);
				if (pay_done) begin
					phase_d = PH_KEY;
				end
				if (last) begin
					end_v  = 1'b1;
					end_st = pay_done ? ST_OK : ST_TRUNCATED;
					stop   = 1'b1;
				end
			end
			PH_DISCARD: begin
				if (last) begin
					phase_d = PH_KEY;
				end
			end
			default: begin
				phase_d = PH_KEY;
			end
		endcase

		// Message end or error resets the parser; early errors go to discard.
		if (stop) begin
			phase_d = to_discard ? PH_DISCARD : PH_KEY;
			acc_d   = 64'd0;
			shift_d = 6'd0;
			fcnt_d  = 3'd0;
		end
	end

	// A field result, when there is one, always comes before the message end.
	always_comb begin
		end_r              = make_end(end_st);
		end_r.last_of_run  = 1'b1;
		run.valid          = main_v || end_v;
		run.second         = main_v && end_v;
		run.res_b          = end_r;
		if (main_v) begin
			run.res_a             = main_r;
			run.res_a.last_of_run = !end_v;
		end else begin
			run.res_a = end_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_q   <= 64'd0;
			shift_q <= 6'd0;
			fcnt_q  <= 3'd0;
			tag_q   <= 61'd0;
			wt_q    <= 3'd0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			shift_q <= shift_d;
			fcnt_q  <= fcnt_d;
			tag_q   <= tag_d;
			wt_q    <= wt_d;
			rem_q   <= rem_d;
		end
	end

endmodule

>>> sv/protobuf_wire_field_parser.sv
// Top level of the protobuf wire field parser: decoder and result queue.
`timescale 1ns / 1ps

// The parser takes an encoded protobuf message one byte per item, with
// is_last set on the final byte, and gives field results: varint values
// with a flag for values wider than 32 bits, fixed32 and fixed64 values
// assembled little-endian, a header carrying the length of each
// length-delimited field followed by its payload bytes one per result, and
// exactly one message-end result per message that carries the status.
// Nested messages are passed through as payload and not parsed. An overlong
// varint, a message that stops mid-field or a length wider than LENGTH_BITS
// ends the message at once with an error status, and the bytes that follow
// up to the final byte give no results. An invalid wire type gives a result
// with the invalid wire type status and parsing goes on with the next key.
// Timing: every input byte is decoded in the cycle it is accepted and its
// results land in a two-entry queue of result groups, so a new byte can be
// taken in every cycle as long as the queue has room. A byte gives zero,
// one or two results; the output hands out one result per cycle while
// out_ready is high, so the sustained rate is one byte per cycle, except
// that a byte giving two results (any field, header or payload result on
// the final byte of a message) holds the output for both results in turn.
// Results are registered in the queue before they reach the output, and
// they wait there while earlier groups are still in the queue.
module protobuf_wire_field_parser import pbwf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pbwf_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output pbwf_out_t out_item
);

	`include "protobuf_wire_field_parser_macros.svh"

	pbwf_run_t  run;
	pbwf_run_t  slot_q [2];
	pbwf_run_t  head;
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       sel_q;
	logic       in_acc;
	logic       out_acc;
	logic       push;
	logic       pop;

	pbwf_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (in_acc),
		.in_item (in_item),
		.run     (run)
	);

	// The queue holds result groups; a byte with no result is not queued.
	assign in_ready  = cnt_q != 2'd2;
	assign in_acc    = in_valid && in_ready;
	assign push      = in_acc && run.valid;

	assign head      = slot_q[rd_q];
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = sel_q ? head.res_b : head.res_a;
	assign out_acc   = out_valid && out_ready;

	// A group leaves the queue once its final result has been taken.
	assign pop       = out_acc && (sel_q || !head.second);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q  <= !rd_q;
				sel_q <= 1'b0;
			end else if (out_acc) begin
				sel_q <= 1'b1;
			end
		end
	end

	`PBWF_CHECK(a_cnt_range, cnt_q <= 2'd2, "result queue count out of range")
	`PBWF_IMPLIES(a_end_closes_run, out_valid && out_item.kind == KIND_END,
		out_item.last_of_run, "message end is not the final result of its byte")
	`PBWF_IMPLIES(a_open_run_first, out_valid && !out_item.last_of_run, !sel_q,
		"second result of a group is not marked final")
	`PBWF_NEXT(a_pair_follows, out_acc && !out_item.last_of_run, out_valid && sel_q,
		"second result of a group did not follow the first")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the protobuf wire field parser with random stimulus.

module tb;
	import pbwf_pkg::*;

	// The slowest correct run is roughly 1000 bytes.
	// The limit leaves a wide margin on top of that.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 800;
	localparam int REPORT_LIMIT = 20;
	localparam int DRAIN_CYCLES = 8;

	// Where the parser stands within the current field.
	typedef enum {
		P_KEY,
		P_VARINT,
		P_FIXED,
		P_LEN,
		P_PAYLOAD,
		P_DISCARD
	} parse_phase_e;

	// Outcome of feeding one byte to a varint being assembled.
	typedef enum {
		VB_MORE,
		VB_DONE,
		VB_OVERLONG
	} varint_step_e;

	// The ledger tracks the parser's state on its own. For every byte that
	// is accepted it predicts the field results, and it checks the results
	// that come out against those predictions in order.
	class field_ledger;
		parse_phase_e phase;
		logic [63:0] acc;
		logic [6:0] shift;
		logic [60:0] tag;
		logic [2:0] wt;
		logic [3:0] fcount;
		logic [63:0] remaining;
		pbwf_out_t due_results[$];
		int failures = 0;
		int n_bytes = 0;
		int n_results = 0;
		int kind_seen[6] = '{default: 0};
		int end_status[4] = '{default: 0};
		int bad_wt_seen = 0;

		function new();
			restart();
		endfunction

		function void restart();
			phase = P_KEY;
			acc = '0;
			shift = '0;
			tag = '0;
			wt = '0;
			fcount = '0;
			remaining = '0;
		endfunction

		function void add(pbwf_kind_t kind, logic [60:0] ftag, logic [2:0] fwt,
			logic [63:0] val, logic wide, logic [7:0] pb, logic pe, pbwf_status_t st);
			pbwf_out_t r;
			r.kind = kind;
			r.field_tag = ftag;
			r.wire_type = fwt;
			r.field_value = val;
			r.value_wide = wide;
			r.payload_byte = pb;
			r.payload_end = pe;
			r.status = st;
			r.last_of_run = 1'b0;
			due_results = {due_results, r};
		endfunction

		// An error ends the message at once. If the byte was not the final
		// one, the rest of the message is thrown away.
		function void close_error(pbwf_status_t st, logic last);
			add(KIND_END, '0, '0, '0, 1'b0, '0, 1'b0, st);
			restart();
			if (!last)
				phase = P_DISCARD;
		endfunction

		function void close_ok(logic last);
			if (last) begin
				add(KIND_END, '0, '0, '0, 1'b0, '0, 1'b0, ST_OK);
				restart();
			end
		endfunction

		// At shift 63 only bit 0 of the byte still fits in 64 bits.
		function varint_step_e varint_byte(logic [7:0] b);
			if (shift == 7'd63 && b[7:1] != 7'd0)
				return VB_OVERLONG;
			if (shift < 7'd64)
				acc = acc | ({57'd0, b[6:0]} << shift);
			shift = shift + 7'd7;
			return b[7] ? VB_MORE : VB_DONE;
		endfunction

		function void take_byte(pbwf_in_t item);
			logic [7:0] b;
			logic last;
			logic [63:0] v;
			logic done;
			int need;
			int n_prior;
			varint_step_e step;
			pbwf_out_t t;
			b = item.in_byte;
			last = item.is_last;
			n_prior = due_results.size();
			n_bytes++;
			case (phase)
				P_KEY, P_VARINT, P_LEN: begin
					step = varint_byte(b);
					if (step == VB_OVERLONG) begin
						close_error(ST_OVERLONG, last);
					end else if (step == VB_MORE) begin
						if (last)
							close_error(ST_TRUNCATED, 1'b1);
					end else begin
						v = acc;
						acc = '0;
						shift = '0;
						if (phase == P_KEY) begin
							tag = v[63:3];
							wt = v[2:0];
							fcount = '0;
							case (wt)
								WT_VARINT: phase = P_VARINT;
								WT_FIXED64, WT_FIXED32: phase = P_FIXED;
								WT_LEN: phase = P_LEN;
								default: begin
									// An unknown wire type is reported; a key follows.
									add(KIND_VARINT, tag, wt, '0, 1'b0, '0, 1'b0, ST_BAD_WT);
									close_ok(last);
								end
							endcase
							// A key of a valid wire type on the final byte leaves the field open.
							if (phase != P_KEY && last)
								close_error(ST_TRUNCATED, 1'b1);
						end else if (phase == P_VARINT) begin
							add(KIND_VARINT, tag, wt, v, v > 64'hffff_ffff, '0, 1'b0, ST_OK);
							phase = P_KEY;
							close_ok(last);
						end else if ((v >> LENGTH_BITS) != 64'd0) begin
							// A length too wide for the length field ends the message.
							close_error(ST_TRUNCATED, last);
						end else begin
							add(KIND_LEN_HDR, tag, wt, v, 1'b0, '0, 1'b0, ST_OK);
							if (v == 64'd0) begin
								phase = P_KEY;
								close_ok(last);
							end else begin
								remaining = v;
								phase = P_PAYLOAD;
								if (last)
									close_error(ST_TRUNCATED, 1'b1);
							end
						end
					end
				end
				P_FIXED: begin
					need = (wt == WT_FIXED64) ? 8 : 4;
					acc = acc | ({56'd0, b} << {fcount[2:0], 3'b000});
					fcount = fcount + 4'd1;
					if (int'(fcount) >= need) begin
						add((need == 8) ? KIND_FIXED64 : KIND_FIXED32, tag, wt, acc, 1'b0,
							'0, 1'b0, ST_OK);
						acc = '0;
						fcount = '0;
						phase = P_KEY;
						close_ok(last);
					end else if (last) begin
						close_error(ST_TRUNCATED, 1'b1);
					end
				end
				P_PAYLOAD: begin
					if (remaining != 64'd0)
						remaining = remaining - 64'd1;
					done = (remaining == 64'd0);
					add(KIND_PAYLOAD, tag, wt, '0, 1'b0, b, done, ST_OK);
					if (done)
						phase = P_KEY;
					if (last) begin
						if (done)
							close_ok(1'b1);
						else
							close_error(ST_TRUNCATED, 1'b1);
					end
				end
				default: begin
					// Bytes after an error are dropped until the final byte of the message.
					if (last)
						restart();
				end
			endcase
			if (due_results.size() > n_prior) begin
				t = due_results.pop_back();
				t.last_of_run = 1'b1;
				due_results = {due_results, t};
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
						$time, name, want, got);
			end
		endfunction

		function void match_result(pbwf_out_t got);
			pbwf_out_t want;
			if (due_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display({"%0t ns: result with nothing expected, expected none, ",
						"actual kind %0d"}, $time, got.kind);
				return;
			end
			want = due_results.pop_front();
			n_results++;
			kind_seen[int'(want.kind)]++;
			if (want.kind == KIND_END)
				end_status[int'(want.status)]++;
			if (want.status == ST_BAD_WT)
				bad_wt_seen++;
			check_field("kind", 64'(want.kind), 64'(got.kind));
			check_field("field_tag", 64'(want.field_tag), 64'(got.field_tag));
			check_field("wire_type", 64'(want.wire_type), 64'(got.wire_type));
			check_field("field_value", want.field_value, got.field_value);
			check_field("value_wide", 64'(want.value_wide), 64'(got.value_wide));
			check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
			check_field("payload_end", 64'(want.payload_end), 64'(got.payload_end));
			check_field("status", 64'(want.status), 64'(got.status));
			check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pbwf_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pbwf_out_t out_item;

	field_ledger ledger;
	int cycle_count = 0;
	int burst_left = 0;
	int bytes_sent = 0;
	int discarded = 0;
	int messages = 0;
	int stall_mode = 0;
	int stall_left = 0;
	logic [7:0] msg[$];

	protobuf_wire_field_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled here, on the values from before the edge.
	// The byte is noted before any result is checked, so the order within
	// the time step never matters. The receiver's stall pattern switches
	// at random among four modes: always ready, a coin flip, mostly
	// stalled, and a fixed periodic gap.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_valid && in_ready)
			ledger.take_byte(in_item);
		if (out_valid && out_ready)
			ledger.match_result(out_item);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycle_count % 7) < 5;
		endcase
	end

	function automatic void put_varint(input logic [63:0] v);
		logic [63:0] rest;
		rest = v;
		while (rest > 64'h7f) begin
			msg = {msg, {1'b1, rest[6:0]}};
			rest = rest >> 7;
		end
		msg = {msg, {1'b0, rest[6:0]}};
	endfunction

	// A random value of the given width. Most often its top bit is set, so
	// that the width really is reached.
	function automatic logic [63:0] rand_bits(input int width);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (width < 64)
			v = v & ((64'd1 << width) - 64'd1);
		if ($urandom_range(0, 3) != 0)
			v[width - 1] = 1'b1;
		return v;
	endfunction

	function automatic logic [60:0] rand_tag();
		logic [63:0] v;
		v = rand_bits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 61)
			: $urandom_range(1, 8));
		return v[60:0];
	endfunction

	function automatic void put_key(input logic [60:0] ftag, input logic [2:0] fwt);
		put_varint({ftag, fwt});
	endfunction

	// One random field: mostly well formed, sometimes a key with an invalid wire type.
	function automatic void put_field();
		int pick;
		int len;
		logic [2:0] bad;
		pick = $urandom_range(0, 10);
		if (pick < 3) begin
			put_key(rand_tag(), WT_VARINT);
			put_varint(rand_bits($urandom_range(1, 64)));
		end else if (pick < 5) begin
			put_key(rand_tag(), WT_FIXED32);
			repeat (4) msg = {msg, 8'($urandom)};
		end else if (pick < 7) begin
			put_key(rand_tag(), WT_FIXED64);
			repeat (8) msg = {msg, 8'($urandom)};
		end else if (pick < 10) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			put_key(rand_tag(), WT_LEN);
			put_varint(64'(len));
			repeat (len) msg = {msg, 8'($urandom)};
		end else begin
			case ($urandom_range(0, 3))
				0: bad = 3'd3;
				1: bad = 3'd4;
				2: bad = 3'd6;
				default: bad = 3'd7;
			endcase
			put_key(rand_tag(), bad);
		end
	endfunction

	// Bursts of random length, with random gaps between them. About one
	// burst in four follows the last one with no gap at all.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		in_item <= {b, last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
		messages++;
	endtask

	// Hold the sender back until every predicted result has come out. The
	// first edge lets the monitor note the byte that was just accepted.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, ledger.pending());
		$display("status: fail");
		$finish;
	end

	initial begin
		int pick;
		int cut;
		int tail;
		ledger = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A varint of 150 that completes on the final byte.
		msg = '{8'h08, 8'h96, 8'h01};
		send_message();
		// An empty length-delimited field, then an invalid wire type on the final byte.
		msg = '{8'h12, 8'h00, 8'h1b};
		send_message();
		// The message stops in the middle of a payload.
		msg = '{8'h12, 8'h02, 8'haa};
		send_message();
		// A key that runs too long, then a dropped byte of value zero that ends the message.
		msg = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h02, 8'h00};
		send_message();
		// A length of 2**32 on the final byte is too wide for the length field.
		msg = '{8'h12, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
		send_message();
		wait_drained();

		// Most messages are well formed. The rest are truncated, carry an
		// overlong varint or a length that is too wide, or are plain noise.
		while (bytes_sent - discarded < RANDOM_BYTES + 26) begin
			msg.delete();
			pick = $urandom_range(0, 99);
			repeat ($urandom_range(1, 4)) put_field();
			if (pick < 12) begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut)
					void'(msg.pop_back());
			end else if (pick < 18) begin
				case ($urandom_range(0, 2))
					1: put_key(rand_tag(), WT_VARINT);
					2: put_key(rand_tag(), WT_LEN);
					default: ;
				endcase
				repeat (9) msg = {msg, {1'b1, 7'($urandom)}};
				msg = {msg, 8'($urandom_range(2, 255))};
				tail = $urandom_range(0, 4);
				repeat (tail) msg = {msg, 8'($urandom)};
				discarded += tail;
			end else if (pick < 23) begin
				put_key(rand_tag(), WT_LEN);
				put_varint(rand_bits($urandom_range(33, 64)) | 64'h1_0000_0000);
				tail = $urandom_range(0, 4);
				repeat (tail) msg = {msg, 8'($urandom)};
				discarded += tail;
			end else if (pick < 28) begin
				msg.delete();
				repeat ($urandom_range(1, 8)) msg = {msg, 8'($urandom)};
			end
			send_message();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display({"covered %0d bytes in %0d messages; %0d results: %0d varint, ",
			"%0d fixed32, %0d fixed64, %0d headers, %0d payload, %0d ends"},
			bytes_sent, messages, ledger.n_results, ledger.kind_seen[0], ledger.kind_seen[1],
			ledger.kind_seen[2], ledger.kind_seen[3], ledger.kind_seen[4], ledger.kind_seen[5]);
		$display({"message ends: %0d ok, %0d overlong, %0d truncated or oversize; ",
			"%0d invalid wire types"},
			ledger.end_status[0], ledger.end_status[1], ledger.end_status[2], ledger.bad_wt_seen);
		if (ledger.failures == 0 && ledger.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/pbwf_pkg.sv
sv/pbwf_decode.sv
sv/protobuf_wire_field_parser.sv
tb/tb.sv
